>>> src/fpr_pkg.sv
// fpr_pkg: shared types, codes and the event length table of the
// front panel response framer. No dependencies.
package fpr_pkg;

  // result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_ANSWER = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_END_MARKER = 2'd0;
  localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;

  localparam logic [7:0] END_MARKER_RST = 8'd3;
  localparam logic [3:0] MIN_LENGTH_RST = 4'd5;

  // event codes
  localparam logic [7:0] EV_BUTTON  = 8'h51;
  localparam logic [7:0] EV_REMOTE  = 8'h63;
  localparam logic [7:0] EV_TIME    = 8'h15;
  localparam logic [7:0] EV_WAKE    = 8'h81;
  localparam logic [7:0] EV_INFO    = 8'hd4;
  localparam logic [7:0] EV_ANSWER0 = 8'he9;
  localparam logic [7:0] EV_ANSWER1 = 8'hf9;

  // first payload byte of an answer frame
  localparam int unsigned ANSWER_FIRST = 3;
  // position of the event byte
  localparam int unsigned EVENT_POS    = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOTE,
    ST_READ,
    ST_SEND
  } fpr_state_t;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_DROP,
    DEC_EMIT
  } fpr_dec_t;

  typedef struct packed {
    logic accept;
    logic load_drop;
    logic load_data;
    logic clear;
  } fpr_cmd_t;

  typedef struct packed {
    fpr_dec_t dec;
    logic     out_free;
    logic     run_last;
  } fpr_status_t;

  function automatic logic [3:0] length_for_event(input logic [7:0] ev);
    logic [3:0] len;
    case (ev)
      EV_BUTTON:  len = 4'd5;
      EV_REMOTE:  len = 4'd7;
      EV_TIME:    len = 4'd9;
      EV_WAKE:    len = 4'd5;
      EV_INFO:    len = 4'd8;
      EV_ANSWER0: len = 4'd13;
      EV_ANSWER1: len = 4'd13;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

>>> src/fpr_ram.sv
// fpr_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/fpr_datapath.sv
// fpr_datapath: configuration registers, frame counters, frame store,
// frame decision and the output register. Uses fpr_pkg and fpr_ram.
module fpr_datapath #(
  parameter int MAX_FRAME_BYTES = 16,
  localparam int AW = $clog2(MAX_FRAME_BYTES),
  localparam int LW = AW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [7:0]          in_rx_byte,
  input  logic                out_ready,
  input  fpr_pkg::fpr_cmd_t   cmd,
  output fpr_pkg::fpr_status_t status,
  output logic                out_valid,
  output logic [1:0]          out_result_kind,
  output logic [7:0]          out_event_code,
  output logic [7:0]          out_data_byte,
  output logic [3:0]          out_byte_index,
  output logic                out_last
);

  logic [7:0]    end_marker_r;
  logic [3:0]    min_len_r;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [3:0]    exp_r, exp_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] end_addr_r, end_addr_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          key_r, key_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_event_r, out_event_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic [3:0]    out_index_r, out_index_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0]    rd_data;
  logic [LW-1:0] len;
  logic          at_event;
  logic [3:0]    exp_eff;
  logic [7:0]    held_eff;
  logic          is_marker, short_frame, no_exp, len_eq, len_ge, full;
  logic          emit_ok, drop;
  logic          is_key;
  fpr_pkg::fpr_dec_t dec;

  fpr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.accept),
    .wr_addr(pos_r),
    .wr_data(in_rx_byte),
    .rd_addr(rd_addr_r),
    .rd_data(rd_data)
  );

  // frame decision for the byte being transferred
  always_comb begin
    len         = LW'(pos_r) + LW'(1);
    at_event    = (pos_r == AW'(fpr_pkg::EVENT_POS));
    exp_eff     = at_event ? fpr_pkg::length_for_event(in_rx_byte) : exp_r;
    held_eff    = at_event ? in_rx_byte : held_r;
    is_marker   = (in_rx_byte == end_marker_r);
    short_frame = (len < LW'(min_len_r));
    no_exp      = (exp_eff == 4'd0);
    len_eq      = (len == LW'(exp_eff));
    len_ge      = (len >= LW'(exp_eff));
    full        = (len >= LW'(MAX_FRAME_BYTES));
    emit_ok     = is_marker && !short_frame && !no_exp && len_eq;
    drop        = is_marker ? (short_frame || no_exp) : (!no_exp && len_ge);
    is_key      = (held_eff == fpr_pkg::EV_BUTTON) || (held_eff == fpr_pkg::EV_REMOTE);
    if (emit_ok) begin
      dec = fpr_pkg::DEC_EMIT;
    end else if (drop || full) begin
      dec = fpr_pkg::DEC_DROP;
    end else begin
      dec = fpr_pkg::DEC_NONE;
    end
  end

  always_comb begin
    status.dec      = dec;
    status.out_free = !out_valid_r || out_ready;
    status.run_last = (rd_addr_r == end_addr_r);
  end

  always_comb begin
    pos_nxt      = pos_r;
    held_nxt     = held_r;
    exp_nxt      = exp_r;
    rd_addr_nxt  = rd_addr_r;
    end_addr_nxt = end_addr_r;
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    if (cmd.accept) begin
      held_nxt = held_eff;
      if (dec == fpr_pkg::DEC_NONE) begin
        pos_nxt = pos_r + AW'(1);
        exp_nxt = exp_eff;
      end else begin
        pos_nxt = '0;
        exp_nxt = 4'd0;
      end
      if (dec == fpr_pkg::DEC_EMIT) begin
        key_nxt = is_key;
        cnt_nxt = 4'd0;
        if (is_key) begin
          rd_addr_nxt  = '0;
          end_addr_nxt = pos_r;
        end else begin
          rd_addr_nxt  = AW'(fpr_pkg::ANSWER_FIRST);
          end_addr_nxt = pos_r - AW'(1);
        end
      end
    end
    if (cmd.load_data) begin
      rd_addr_nxt = rd_addr_r + AW'(1);
      cnt_nxt     = cnt_r + 4'd1;
    end
    if (cmd.clear) begin
      held_nxt = 8'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_event_nxt = out_event_r;
    out_data_nxt  = out_data_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    if (cmd.load_drop) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = fpr_pkg::KIND_DROP;
      out_event_nxt = held_r;
      out_data_nxt  = 8'd0;
      out_index_nxt = 4'd0;
      out_last_nxt  = 1'b1;
    end else if (cmd.load_data) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = key_r ? fpr_pkg::KIND_KEY : fpr_pkg::KIND_ANSWER;
      out_event_nxt = held_r;
      out_data_nxt  = rd_data;
      out_index_nxt = cnt_r;
      out_last_nxt  = status.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_marker_r <= fpr_pkg::END_MARKER_RST;
      min_len_r    <= fpr_pkg::MIN_LENGTH_RST;
      pos_r        <= '0;
      held_r       <= 8'd0;
      exp_r        <= 4'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == fpr_pkg::CFG_END_MARKER) begin
        end_marker_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == fpr_pkg::CFG_MIN_LENGTH) begin
        min_len_r <= cfg_data[3:0];
      end
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    end_addr_r  <= end_addr_nxt;
    cnt_r       <= cnt_nxt;
    key_r       <= key_nxt;
    out_kind_r  <= out_kind_nxt;
    out_event_r <= out_event_nxt;
    out_data_r  <= out_data_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_event_code  = out_event_r;
  assign out_data_byte   = out_data_r;
  assign out_byte_index  = out_index_r;
  assign out_last        = out_last_r;

endmodule

>>> src/fpr_ctrl.sv
// fpr_ctrl: controller state machine of the framer; sequences byte
// transfers, drop notices and frame emission. Uses fpr_pkg.
module fpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpr_pkg::fpr_status_t status,
  output fpr_pkg::fpr_cmd_t    cmd
);

  fpr_pkg::fpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (status.dec)
            fpr_pkg::DEC_DROP: state_nxt = fpr_pkg::ST_NOTE;
            fpr_pkg::DEC_EMIT: state_nxt = fpr_pkg::ST_READ;
            default:           state_nxt = fpr_pkg::ST_IDLE;
          endcase
        end
      end
      fpr_pkg::ST_NOTE: begin
        if (status.out_free) begin
          cmd.load_drop = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = fpr_pkg::ST_IDLE;
        end
      end
      // store read issued; data is registered for the next cycle
      fpr_pkg::ST_READ: begin
        state_nxt = fpr_pkg::ST_SEND;
      end
      fpr_pkg::ST_SEND: begin
        if (status.out_free) begin
          cmd.load_data = 1'b1;
          if (status.run_last) begin
            cmd.clear = 1'b1;
            state_nxt = fpr_pkg::ST_IDLE;
          end else begin
            state_nxt = fpr_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = fpr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/front_panel_response_framer.sv
// Front panel response framer, top level. Uses fpr_pkg, fpr_ctrl, fpr_datapath.
// A byte that does not end a frame leaves the controller idle, so the next byte may follow at once.
// A drop notice is loaded into the output register from the NOTE state, once that register is free.
// Each byte of an emitted run is one frame store read (registered, READ state)
// plus one output register load (SEND state). Output stalls hold the sequencer.
// Reset (synchronous, rst_n low) clears position, expected length, held event and output valid, sets config defaults.
module front_panel_response_framer #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_event_code,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_byte_index,
  output logic       out_last
);

  fpr_pkg::fpr_cmd_t    cmd;
  fpr_pkg::fpr_status_t status;

  assign cfg_ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  fpr_datapath #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_rx_byte     (in_rx_byte),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_result_kind(out_result_kind),
    .out_event_code (out_event_code),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

>>> tb/fpr_response_checker.sv
// fpr_response_checker: watches the byte, config and result channels of the framer,
// predicts every result from the accepted bytes and counts mismatches.
// Depends on fpr_pkg.
module fpr_response_checker #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_result_kind,
  input  logic [7:0] out_event_code,
  input  logic [7:0] out_data_byte,
  input  logic [3:0] out_byte_index,
  input  logic       out_last,
  output int         pending,
  output int         fail_count
);
  import fpr_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ev;
    logic [7:0] data;
    logic [3:0] idx;
    logic       last;
  } framer_result_t;

  framer_result_t due_results [$];

  // predicted framer state and register copies
  logic [7:0] frame_bytes [MAX_FRAME_BYTES];
  int         fill_count;
  logic [7:0] frame_event;
  int         frame_len_due;
  logic [7:0] close_byte;
  logic [3:0] shortest_len;

  initial fail_count = 0;

  function automatic int frame_length_of(input logic [7:0] code);
    int n;
    case (code)
      EV_BUTTON, EV_WAKE:     n = 5;
      EV_REMOTE:              n = 7;
      EV_INFO:                n = 8;
      EV_TIME:                n = 9;
      EV_ANSWER0, EV_ANSWER1: n = 13;
      default:                n = 0;
    endcase
    return n;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                              input int idx, input logic last);
    framer_result_t r;
    r.kind = kind;
    r.ev   = frame_event;
    r.data = data;
    r.idx  = idx[3:0];
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int  slot;
    int  len;
    bit  drop;
    bit  emit;
    slot = (fill_count >= MAX_FRAME_BYTES) ? MAX_FRAME_BYTES - 1 : fill_count;
    frame_bytes[slot] = b;
    len = slot + 1;
    fill_count = len;
    drop = 1'b0;
    emit = 1'b0;
    if (slot == EVENT_POS) begin
      frame_event = b;
      frame_len_due = frame_length_of(b);
    end
    if (b == close_byte) begin
      if (len < int'(shortest_len) || frame_len_due == 0) drop = 1'b1;
      else if (len == frame_len_due) emit = 1'b1;
    end else if (frame_len_due != 0 && len >= frame_len_due) begin
      drop = 1'b1;
    end
    if (!drop && !emit && len >= MAX_FRAME_BYTES) drop = 1'b1;

    if (drop) begin
      queue_result(KIND_DROP, 8'h00, 0, 1'b1);
    end else if (emit) begin
      // key frames go out whole, answers only their payload
      if (frame_event == EV_BUTTON || frame_event == EV_REMOTE) begin
        for (int i = 0; i < len; i++)
          queue_result(KIND_KEY, frame_bytes[i], i, i == len - 1);
      end else begin
        for (int i = ANSWER_FIRST; i < len - 1; i++)
          queue_result(KIND_ANSWER, frame_bytes[i], i - ANSWER_FIRST, i == len - 2);
      end
    end
    if (drop || emit) begin
      fill_count = 0;
      frame_event = 8'h00;
      frame_len_due = 0;
    end
  endtask

  always @(posedge clk) begin
    framer_result_t want;
    if (!rst_n) begin
      due_results.delete();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      fill_count = 0;
      frame_event = 8'h00;
      frame_len_due = 0;
      close_byte = END_MARKER_RST;
      shortest_len = MIN_LENGTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_END_MARKER: close_byte = cfg_data;
          CFG_MIN_LENGTH: shortest_len = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", out_data_byte, 0);
        end else begin
          want = due_results.pop_front();
          if (out_result_kind !== want.kind)
            flag_mismatch("result_kind", out_result_kind, want.kind);
          if (out_event_code !== want.ev)
            flag_mismatch("event_code", out_event_code, want.ev);
          if (out_data_byte !== want.data)
            flag_mismatch("data_byte", out_data_byte, want.data);
          if (out_byte_index !== want.idx)
            flag_mismatch("byte_index", out_byte_index, want.idx);
          if (out_last !== want.last)
            flag_mismatch("last", out_last, want.last);
        end
      end
      if (in_valid && in_ready) absorb_byte(in_rx_byte);
    end
    pending <= due_results.size();
  end

endmodule

>>> tb/front_panel_response_framer_tb.sv
// front_panel_response_framer_tb: feeds received bytes and register writes to the framer,
// throttles the result side and reports the verdict.
// Depends on fpr_pkg, the framer RTL and fpr_response_checker.
module front_panel_response_framer_tb;
  import fpr_pkg::*;

  localparam int MAX_FRAME_BYTES = 16;
  localparam int SETTLE = 24;
  localparam int PHASES = 6;
  localparam logic [1:0] CFG_SPARE2 = 2'd2;
  localparam logic [1:0] CFG_SPARE3 = 2'd3;

  // key frame with extreme bytes, early marker, remote frame with an inner marker,
  // wake frame missing its marker, unknown event closed by a marker
  localparam logic [7:0] DIRECTED [25] = '{
    8'h00, 8'hff, 8'h51, 8'hff, 8'h03,
    8'h00, 8'h03,
    8'h01, 8'h02, 8'h63, 8'h80, 8'h03, 8'h7f, 8'h03,
    8'h10, 8'h20, 8'h81, 8'h40, 8'h55,
    8'h04, 8'h05, 8'h77, 8'h08, 8'haa, 8'h03
  };
  localparam logic [7:0] EVENTS [7] = '{
    EV_BUTTON, EV_REMOTE, EV_TIME, EV_WAKE, EV_INFO, EV_ANSWER0, EV_ANSWER1
  };
  localparam int EVENT_LEN [7] = '{5, 7, 9, 5, 8, 13, 13};
  localparam logic [7:0] PHASE_MARKER [PHASES] = '{8'h03, 8'hff, 8'h00, 8'h7e, 8'ha5, 8'h55};
  // upper nibble of a length write is ignored by the block
  localparam logic [7:0] PHASE_MIN [PHASES] = '{8'h05, 8'h03, 8'h3d, 8'h0f, 8'h00, 8'h08};
  localparam int PHASE_ITEMS [PHASES] = '{90, 90, 90, 40, 60, 110};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_END_MARKER;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_event_code;
  logic [7:0] out_data_byte;
  logic [3:0] out_byte_index;
  logic       out_last;

  int         pending;
  int         fail_count;
  logic       steady = 1'b0;
  logic [7:0] close_now = END_MARKER_RST;
  int         bytes_sent = 0;
  int         target = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  front_panel_response_framer #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) dut (.*);

  fpr_response_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) resp_check (.*);

  always @(posedge clk)
    out_ready <= rst_n && (steady || $urandom_range(99) >= 24);

  task automatic push_byte(input logic [7:0] value);
    if (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the byte side until every predicted result has been transferred
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well formed frames; the rest lack the marker, carry an unknown event,
  // run overlong, close early or are plain noise
  task automatic random_frame();
    logic [7:0] frame [$];
    logic [7:0] b;
    int pick;
    int n;
    int ev;
    pick = $urandom_range(99);
    ev = $urandom_range(6);
    if (pick < 80) n = EVENT_LEN[ev];
    else if (pick < 88) n = ($urandom_range(3) == 0) ? MAX_FRAME_BYTES : $urandom_range(4, 15);
    else if (pick < 94) n = $urandom_range(2, 5);
    else n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      // now and then keep a marker inside a known frame
      if (b == close_now && !(pick < 80 && $urandom_range(7) == 0)) b = ~b;
      if (pick < 88 && i == EVENT_POS) begin
        b = EVENTS[ev];
        // flipping bit 0 never lands on a known event
        if (pick >= 80) b = b ^ 8'h01;
      end
      if (i == n - 1) begin
        if (pick < 70 || (pick >= 80 && pick < 94 && n < MAX_FRAME_BYTES)) b = close_now;
        else if (b == close_now) b = ~b;
      end
      frame.push_back(b);
    end
    foreach (frame[i]) push_byte(frame[i]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) push_byte(DIRECTED[i]);
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_reg(CFG_END_MARKER, PHASE_MARKER[p]);
      write_reg(CFG_MIN_LENGTH, PHASE_MIN[p]);
      if (p == 0) begin
        // unused indexes must leave both registers alone
        write_reg(CFG_SPARE2, 8'($urandom));
        write_reg(CFG_SPARE3, 8'hff);
      end
      close_now = PHASE_MARKER[p];
      steady <= (p == 1);
      target += PHASE_ITEMS[p];
      while (bytes_sent < target) random_frame();
    end
    wait_quiet();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
src/fpr_pkg.sv
src/fpr_ram.sv
src/fpr_datapath.sv
src/fpr_ctrl.sv
src/front_panel_response_framer.sv
tb/fpr_response_checker.sv
tb/front_panel_response_framer_tb.sv
